// ===== design/xtea_pkg.sv =====
// Shared types, constants and the mixing function of the XTEA cipher pipeline.
`default_nettype none

package xtea_pkg;

  localparam logic [31:0] XTEA_DELTA    = 32'h9E37_79B9;
  localparam int          KEY_SEL_SHIFT = 11;
  localparam int          KEY_WORDS     = 4;
  localparam int          APB_ADDR_W    = 4;

  typedef logic [31:0] word_t;
  typedef word_t [KEY_WORDS-1:0] key_words_t;

  typedef struct packed {
    logic valid;
    logic decrypt;
  } stage_ctrl_t;

  function automatic word_t mix_word(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

`default_nettype wire

// ===== design/xtea_hround.sv =====
// One Feistel half-round of XTEA as a registered pipeline stage.
`default_nettype none

module xtea_hround import xtea_pkg::*; #(
  parameter logic [31:0] ENC_SUM     = 32'h0000_0000,
  parameter logic [31:0] DEC_SUM     = 32'h0000_0000,
  parameter logic [1:0]  ENC_KEY_IDX = 2'd0,
  parameter logic [1:0]  DEC_KEY_IDX = 2'd0,
  parameter bit          EVEN_STAGE  = 1'b1
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         en_i,
  input  key_words_t  key_i,
  input  stage_ctrl_t ctrl_i,
  input  word_t       a_i,
  input  word_t       b_i,
  output stage_ctrl_t ctrl_o,
  output word_t       a_o,
  output word_t       b_o
);

  stage_ctrl_t ctrl_q;
  word_t       a_q, b_q;
  word_t       a_d, b_d;
  logic        src_is_b;
  word_t       src, dst, sum, key, mixed, upd;

  always_comb begin
    src_is_b = EVEN_STAGE ^ ctrl_i.decrypt;
    src      = src_is_b ? b_i : a_i;
    dst      = src_is_b ? a_i : b_i;
    sum      = ctrl_i.decrypt ? DEC_SUM : ENC_SUM;
    key      = key_i[ctrl_i.decrypt ? DEC_KEY_IDX : ENC_KEY_IDX];
    mixed    = mix_word(src) ^ (sum + key);
    upd      = ctrl_i.decrypt ? (dst - mixed) : (dst + mixed);
    a_d      = src_is_b ? upd : a_i;
    b_d      = src_is_b ? b_i : upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;

endmodule

`default_nettype wire

// ===== design/xtea_block_cipher.sv =====
// Top level of the pipelined XTEA block cipher with its APB key registers.
//
//   Channel  Direction  Handshake                     Payload
//   in       request    in_valid_i / in_stall_o       cmd_i, block_in_i
//   out      result     out_valid_o / out_stall_i     block_out_o
//   cfg      APB write  psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One request enters per cycle unless the output stalls; each half-round is
// one registered pipeline stage, and the result comes from the last stage.
// Reset clears the stage valid bits and the key words to zero.
// A stalled result holds the whole pipeline, and the input stalls with it.
`default_nettype none

module xtea_block_cipher import xtea_pkg::*; #(
  parameter int CYCLE_COUNT = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [APB_ADDR_W-1:0] paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire                   cmd_i,
  input  wire  [63:0]           block_in_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [63:0]           block_out_o
);

  localparam int NUM_STAGES = 2 * CYCLE_COUNT;

  key_words_t  key_q;
  logic [1:0]  reg_idx;
  logic        advance;
  stage_ctrl_t ctrl [NUM_STAGES+1];
  word_t       a_w  [NUM_STAGES+1];
  word_t       b_w  [NUM_STAGES+1];
  logic [NUM_STAGES-1:0] vld;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = key_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (psel && penable && pwrite) begin
      key_q[reg_idx] <= pwdata;
    end
  end

  assign advance    = !(ctrl[NUM_STAGES].valid && out_stall_i);
  assign in_stall_o = !advance;

  assign ctrl[0].valid   = in_valid_i;
  assign ctrl[0].decrypt = cmd_i;
  assign a_w[0]          = block_in_i[31:0];
  assign b_w[0]          = block_in_i[63:32];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam int          N         = k / 2;
    localparam bit          EVEN      = (k % 2) == 0;
    localparam logic [31:0] ENC_SUM   = XTEA_DELTA * 32'(EVEN ? N : N + 1);
    localparam logic [31:0] DEC_SUM   =
      XTEA_DELTA * 32'(EVEN ? CYCLE_COUNT - N : CYCLE_COUNT - N - 1);
    localparam logic [31:0] ENC_SHIFT = ENC_SUM >> KEY_SEL_SHIFT;
    localparam logic [31:0] DEC_SHIFT = DEC_SUM >> KEY_SEL_SHIFT;
    localparam logic [1:0]  ENC_IDX   = EVEN ? ENC_SUM[1:0] : ENC_SHIFT[1:0];
    localparam logic [1:0]  DEC_IDX   = EVEN ? DEC_SHIFT[1:0] : DEC_SUM[1:0];

    xtea_hround #(
      .ENC_SUM     (ENC_SUM),
      .DEC_SUM     (DEC_SUM),
      .ENC_KEY_IDX (ENC_IDX),
      .DEC_KEY_IDX (DEC_IDX),
      .EVEN_STAGE  (EVEN)
    ) u_hround (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .key_i  (key_q),
      .ctrl_i (ctrl[k]),
      .a_i    (a_w[k]),
      .b_i    (b_w[k]),
      .ctrl_o (ctrl[k+1]),
      .a_o    (a_w[k+1]),
      .b_o    (b_w[k+1])
    );

    assign vld[k] = ctrl[k+1].valid;
  end

  assign out_valid_o = ctrl[NUM_STAGES].valid;
  assign block_out_o = {b_w[NUM_STAGES], a_w[NUM_STAGES]};

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld))
    else $error("pipeline valid bits moved while the result was stalled");

  a_req_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_valid_i) |=> !vld[0])
    else $error("first stage became valid without a request");
`endif

endmodule

`default_nettype wire

// ===== dv/xtea_block_cipher_check.sv =====
// Shared testbench codes and the checker that predicts and compares XTEA results.
package xtea_tb_pkg;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } xtea_cmd_e;

  typedef enum logic [1:0] {
    KEY_WORD0,
    KEY_WORD1,
    KEY_WORD2,
    KEY_WORD3
  } key_reg_e;

endpackage

module xtea_block_cipher_check import xtea_pkg::*; import xtea_tb_pkg::*; #(
  parameter int CYCLE_COUNT = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [APB_ADDR_W-1:0] paddr,
  input  wire [31:0]           pwdata,
  input  wire                  pready,
  input  wire                  in_valid_i,
  input  wire                  in_stall_o,
  input  wire                  cmd_i,
  input  wire [63:0]           block_in_i,
  input  wire                  out_valid_o,
  input  wire                  out_stall_i,
  input  wire [63:0]           block_out_o,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  key_words_t  cipher_key;
  logic [63:0] expected_blocks[$];
  logic [63:0] wanted_block;
  int unsigned mismatches;
  int unsigned results_seen;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    mismatches   = 0;
    results_seen = 0;
  end

  function automatic word_t feistel_f(input word_t v);
    return ({v[27:0], 4'b0000} ^ {5'b00000, v[31:5]}) + v;
  endfunction

  function automatic logic [63:0] xtea_encipher(input key_words_t k, input logic [63:0] blk);
    word_t a;
    word_t b;
    word_t s;
    a = blk[31:0];
    b = blk[63:32];
    s = '0;
    for (int n = 0; n < CYCLE_COUNT; n++) begin
      a = a + (feistel_f(b) ^ (s + k[s[1:0]]));
      s = s + XTEA_DELTA;
      b = b + (feistel_f(a) ^ (s + k[s[KEY_SEL_SHIFT +: 2]]));
    end
    return {b, a};
  endfunction

  function automatic logic [63:0] xtea_decipher(input key_words_t k, input logic [63:0] blk);
    word_t a;
    word_t b;
    word_t s;
    a = blk[31:0];
    b = blk[63:32];
    s = XTEA_DELTA * word_t'(CYCLE_COUNT);
    for (int n = 0; n < CYCLE_COUNT; n++) begin
      b = b - (feistel_f(a) ^ (s + k[s[KEY_SEL_SHIFT +: 2]]));
      s = s - XTEA_DELTA;
      a = a - (feistel_f(b) ^ (s + k[s[1:0]]));
    end
    return {b, a};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < 100) begin
      $display("[%0t] result %0d: %s, expected %h, got %h", $realtime, results_seen, what,
               want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cipher_key = '0;
      expected_blocks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        cipher_key[paddr[3:2]] = pwdata;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("block_out with no request outstanding", '0, block_out_o);
        end else begin
          wanted_block = expected_blocks.pop_front();
          if (block_out_o !== wanted_block) begin
            report_mismatch("block_out differs", wanted_block, block_out_o);
          end
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        expected_blocks = {expected_blocks,
                           ((cmd_i == CMD_DECRYPT) ?
                            xtea_decipher(cipher_key, block_in_i) :
                            xtea_encipher(cipher_key, block_in_i))};
      end
    end
    pending_o    <= expected_blocks.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== dv/xtea_block_cipher_tb.sv =====
// Top of the XTEA block cipher testbench: clock, reset, stimulus and verdict.
module xtea_block_cipher_tb import xtea_pkg::*; import xtea_tb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_COUNT     = 32;
  localparam int PHASE_ITEMS     = 512;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 2 * CYCLE_COUNT + 16;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  cmd_i       = 1'b0;
  logic [63:0]           block_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [63:0]           block_out_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned request_gap_pct = 0;
  int unsigned result_stall_pct = 0;
  int unsigned idle_cycles = 0;

  xtea_block_cipher #(.CYCLE_COUNT(CYCLE_COUNT)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .block_in_i  (block_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .block_out_o (block_out_o)
  );

  xtea_block_cipher_check #(.CYCLE_COUNT(CYCLE_COUNT)) cipher_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .block_in_i   (block_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .block_out_o  (block_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < result_stall_pct);
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_block(input xtea_cmd_e cmd, input logic [63:0] blk);
    while ($urandom_range(99) < request_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    block_in_i <= blk;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic await_drain();
    in_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic apb_write(input key_reg_e idx, input word_t value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    @(negedge clk_i);
  endtask

  task automatic load_key(input key_words_t words);
    await_drain();
    for (int i = 0; i < KEY_WORDS; i++) begin
      apb_write(key_reg_e'(i), words[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_block();
    logic [63:0] blk;
    case ($urandom_range(15))
      0:       blk = '0;
      1:       blk = '1;
      2:       blk = 64'd1 << $urandom_range(63);
      3:       blk = ~(64'd1 << $urandom_range(63));
      default: blk = {$urandom, $urandom};
    endcase
    return blk;
  endfunction

  function automatic key_words_t random_key();
    key_words_t words;
    for (int i = 0; i < KEY_WORDS; i++) begin
      words[i] = $urandom;
    end
    return words;
  endfunction

  initial begin : stimulus
    int unsigned gap_table[3];
    int unsigned stall_table[3];
    gap_table   = '{38, 88, 0};
    stall_table = '{88, 38, 0};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_block(CMD_ENCRYPT, 64'h0);
    send_block(CMD_DECRYPT, 64'h0);
    send_block(CMD_ENCRYPT, '1);
    send_block(CMD_DECRYPT, '1);

    load_key('1);
    send_block(CMD_ENCRYPT, 64'h0);
    send_block(CMD_DECRYPT, '1);
    send_block(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    send_block(CMD_DECRYPT, 64'h0123_4567_89AB_CDEF);

    load_key({32'h0F0E_0D0C, 32'h0B0A_0908, 32'h0706_0504, 32'h0302_0100});
    send_block(CMD_ENCRYPT, 64'h4847_4645_4443_4241);
    send_block(CMD_DECRYPT, 64'h4847_4645_4443_4241);
    send_block(CMD_ENCRYPT, 64'h0000_0000_8000_0000);
    send_block(CMD_DECRYPT, 64'h8000_0000_0000_0001);
    send_block(CMD_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(CMD_DECRYPT, 64'h5555_5555_5555_5555);
    send_block(CMD_ENCRYPT, 64'h0000_0001_0000_0000);
    send_block(CMD_DECRYPT, 64'hFFFF_FFFF_0000_0000);

    for (int phase = 0; phase < 3; phase++) begin
      load_key(random_key());
      request_gap_pct  = gap_table[phase];
      result_stall_pct = stall_table[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          load_key((phase == 2) ? {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0} : random_key());
        end
        send_block(xtea_cmd_e'($urandom_range(1)), random_block());
      end
    end

    await_drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
